FILE: design/sft_pkg.sv
package sft_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 32;
    localparam int HND_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_PAIR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_HANDLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // One stored session
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [HND_W-1:0]  hnd;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic              exec;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [HND_W-1:0]  hnd;
    } t_cell_ctl;

endpackage

FILE: design/sft_if.sv
// Command channel
interface sft_cmd_if;
    import sft_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] destination_address;
    logic [HND_W-1:0]  session_handle;

    modport source (
        output valid, command, source_address, destination_address, session_handle,
        input  ready
    );
    modport sink (
        input  valid, command, source_address, destination_address, session_handle,
        output ready
    );
endinterface

// Response channel
interface sft_rsp_if;
    import sft_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [HND_W-1:0]   found_handle;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, status, found_handle, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_handle, entry_count,
        output ready
    );
endinterface

FILE: design/sft_cell.sv
// One table slot: holds an entry, compares it against the key, passes the
// first-match flag and handle down the row, and takes its younger neighbor's
// entry when a removal at or below this slot compacts the row.
module sft_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic               i_clk,
    input  sft_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_hit,
    input  logic [15:0]        i_hnd,
    input  sft_pkg::t_entry    i_up,
    output logic               o_hit,
    output logic [15:0]        o_hnd,
    output sft_pkg::t_entry    o_entry
);
    import sft_pkg::*;

    t_entry r_ent;
    logic   live;
    logic   pair_match;
    logic   hnd_match;
    logic   match;
    logic   is_del;

    // Slot holds a session only below the fill count
    assign live = (CNT_W'(IDX) < i_count);

    // Key compare, both directions of the pair
    assign pair_match = ((r_ent.src == i_ctl.src) && (r_ent.dst == i_ctl.dst)) ||
                        ((r_ent.src == i_ctl.dst) && (r_ent.dst == i_ctl.src));
    assign hnd_match  = (r_ent.hnd == i_ctl.hnd);
    assign match      = live && ((i_ctl.cmd == CMD_DEL_HANDLE) ? hnd_match : pair_match);

    // First-match chain: an older hit wins
    assign o_hit = i_hit | match;
    assign o_hnd = i_hit ? i_hnd : (match ? r_ent.hnd : '0);

    assign is_del  = (i_ctl.cmd == CMD_DEL_PAIR) || (i_ctl.cmd == CMD_DEL_HANDLE);
    assign o_entry = r_ent;

    // Append at the tail, or shift down from the neighbor on removal
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            if ((i_ctl.cmd == CMD_ADD) && (i_count == CNT_W'(IDX))) begin
                r_ent.src <= i_ctl.src;
                r_ent.dst <= i_ctl.dst;
                r_ent.hnd <= i_ctl.hnd;
            end else if (is_del && o_hit) begin
                r_ent <= i_up;
            end
        end
    end
endmodule

FILE: design/symmetric_flow_session_table_top.sv
// Session table of TABLE_ENTRIES slots, kept as a row of cells in insertion
// order, oldest in slot 0. Each command is first taken into the command
// register; in the execute state that follows, every cell compares its entry
// against the key in parallel, the first-match flag ripples along the row,
// and on a removal every younger cell takes its neighbor's entry. The
// result sits in an output register; while it waits there, a new command may
// be taken but does not execute until the result has been accepted. Reset
// needs no clearing pass: only slots below the fill count are ever looked at.
module symmetric_flow_session_table_top #(
    parameter int TABLE_ENTRIES = sft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sft_cmd_if.sink   i_cmd,
    sft_rsp_if.source o_rsp
);
    import sft_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic [HND_W-1:0]   r_hnd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovalid;
    logic [STAT_W-1:0]  r_status;
    logic [STAT_W-1:0]  n_status;
    logic [HND_W-1:0]   r_found;
    logic [HND_W-1:0]   n_found;
    logic [COUNT_W-1:0] r_ocount;

    logic      accept;
    logic      exec;
    t_cell_ctl ctl;

    logic                 w_hit [TABLE_ENTRIES+1];
    logic [HND_W-1:0]     w_hnd [TABLE_ENTRIES+1];
    t_entry               w_ent [TABLE_ENTRIES+1];

    // Handshake
    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign exec        = (r_state == S_EXEC) && (!r_ovalid || o_rsp.ready);

    // Command register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd.command;
            r_src <= i_cmd.source_address;
            r_dst <= i_cmd.destination_address;
            r_hnd <= i_cmd.session_handle;
        end
    end

    // Broadcast to the row
    assign ctl.exec = exec;
    assign ctl.cmd  = r_cmd;
    assign ctl.src  = r_src;
    assign ctl.dst  = r_dst;
    assign ctl.hnd  = r_hnd;

    // Row of cells
    assign w_hit[0]             = 1'b0;
    assign w_hnd[0]             = '0;
    assign w_ent[TABLE_ENTRIES] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        sft_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_count (r_count),
            .i_hit   (w_hit[g]),
            .i_hnd   (w_hnd[g]),
            .i_up    (w_ent[g+1]),
            .o_hit   (w_hit[g+1]),
            .o_hnd   (w_hnd[g+1]),
            .o_entry (w_ent[g])
        );
    end

    // Result and next count
    always_comb begin
        n_count  = r_count;
        n_status = ST_NONE;
        n_found  = '0;
        case (r_cmd)
            CMD_ADD: begin
                if (r_count < CNT_W'(TABLE_ENTRIES)) begin
                    n_count  = r_count + CNT_W'(1);
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_DEL_PAIR, CMD_DEL_HANDLE: begin
                if (w_hit[TABLE_ENTRIES]) begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_DONE;
                end
            end
            CMD_FIND: begin
                if (w_hit[TABLE_ENTRIES]) begin
                    n_found  = w_hnd[TABLE_ENTRIES];
                    n_status = ST_DONE;
                end
            end
            CMD_CLEAR: begin
                n_count  = '0;
                n_status = ST_DONE;
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (exec)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_ocount <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_handle = r_found;
    assign o_rsp.entry_count  = r_ocount;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count above table depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (r_cmd == CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries behind");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (r_cmd == CMD_ADD) && (r_count == CNT_W'(TABLE_ENTRIES)))
        |=> $stable(r_count))
        else $error("add to full table changed the count");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status != ST_DONE)) |-> (r_found == '0))
        else $error("non-zero handle on a miss");
endmodule
